// File: design/tpf_pkg.sv
// Package for the threshold pulse finder: payload structs, queue entry type,
// configuration register indexes and fixed widths. No dependencies.
package tpf_pkg;

  // Fixed widths of the datapath.
  localparam int unsigned IdxW    = 16;
  localparam int unsigned SmpW    = 16;
  localparam int unsigned Q4W     = 20;  // sample or pedestal in Q16.4
  localparam int unsigned ThrW    = 25;  // pedestal + max(fixed, noise)
  localparam int unsigned NoiseW  = 24;  // sigma (8) times rms (16)
  localparam int unsigned AreaW   = 36;
  localparam int unsigned CfgIdxW = 8;

  localparam logic [AreaW-1:0] AreaMax = {AreaW{1'b1}};

  // Register reset values.
  localparam logic [15:0] AdcThresholdRst = 16'd3;
  localparam logic [7:0]  SigmaRst        = 8'd5;
  // Threshold with reset registers: 0 + max(3 << 4, 5 * 0).
  localparam logic [ThrW-1:0] ThrRst      = ThrW'(48);

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CfgAdcThreshold   = 8'd0,
    CfgSigmaMult      = 8'd1,
    CfgPedestalMean   = 8'd2,
    CfgPedestalRms    = 8'd3
  } tpf_cfg_idx_e;

  // Input transaction payload.
  typedef struct packed {
    logic [SmpW-1:0] sample;
    logic            window_end;
  } tpf_in_t;

  // Result transaction payload.
  typedef struct packed {
    logic [IdxW-1:0]  start_index;
    logic [IdxW-1:0]  end_index;
    logic [IdxW-1:0]  peak_index;
    logic [AreaW-1:0] pulse_area;
    logic [Q4W-1:0]   pulse_peak;
    logic             truncated;
  } tpf_out_t;

  // Classified sample passed from the front end to the pulse tracker.
  typedef struct packed {
    logic            above;
    logic [Q4W-1:0]  diff;
    logic [IdxW-1:0] index;
    logic            window_end;
  } tpf_entry_t;

endpackage

// File: design/threshold_pulse_finder_unit.sv
// Top level of the threshold pulse finder: configuration registers, front end,
// queue and pulse tracker. Depends on tpf_pkg, tpf_cfg, tpf_front, tpf_queue, tpf_back.
//
//  Channel   Signals                                   Direction
//  input     in_valid_i, in_ready_o, in_data_i         sample and window-end mark in
//  result    out_valid_o, out_ready_i, out_data_o      one pulse record out
//  config    cfg_valid_i, cfg_ready_o, cfg_index_i,    register write in
//            cfg_data_i
//
// One sample per clock is sustained while the queue has room; a pulse record passes
// through the queue register and then the result register after the sample that
// ends it is accepted (threshold compare before the queue, record update after it).
// The threshold is recomputed in the cycle of a register write and applies to
// the next sample. Reset clears the pulse record, the sample index and queue.
// A stalled result register holds the tracker; the two-entry queue keeps the
// input side open until it fills.
module threshold_pulse_finder_unit #(
  parameter int unsigned MAX_WINDOW  = 65536,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  tpf_pkg::tpf_in_t            in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output tpf_pkg::tpf_out_t           out_data_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [tpf_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]                 cfg_data_i
);
  import tpf_pkg::*;

  logic [ThrW-1:0] thr;
  logic [Q4W-1:0]  mean;
  logic            push, pop, full, empty;
  tpf_entry_t      push_entry, pop_entry;

  tpf_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .thr_o       (thr),
    .mean_o      (mean)
  );

  tpf_front #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .thr_i      (thr),
    .mean_i     (mean),
    .push_o     (push),
    .entry_o    (push_entry),
    .full_i     (full)
  );

  tpf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .entry_o (pop_entry)
  );

  tpf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .entry_i     (pop_entry),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// File: design/tpf_cfg.sv
// Configuration registers and the precomputed Q.4 threshold.
// Depends on tpf_pkg.
module tpf_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [tpf_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [31:0]                  cfg_data_i,
  output logic [tpf_pkg::ThrW-1:0]     thr_o,
  output logic [tpf_pkg::Q4W-1:0]      mean_o
);
  import tpf_pkg::*;

  logic [15:0]      adc_q, adc_d;
  logic [7:0]       sigma_q, sigma_d;
  logic [Q4W-1:0]   mean_q, mean_d;
  logic [15:0]      rms_q, rms_d;
  logic [ThrW-1:0]  thr_q, thr_d;
  logic [NoiseW-1:0] noise_thr;
  logic [Q4W-1:0]   fixed_thr;
  logic [NoiseW-1:0] margin;

  assign cfg_ready_o = 1'b1;

  // Register write decode; unknown indexes are ignored.
  always_comb begin
    adc_d   = adc_q;
    sigma_d = sigma_q;
    mean_d  = mean_q;
    rms_d   = rms_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgAdcThreshold: adc_d   = cfg_data_i[15:0];
        CfgSigmaMult:    sigma_d = cfg_data_i[7:0];
        CfgPedestalMean: mean_d  = cfg_data_i[Q4W-1:0];
        CfgPedestalRms:  rms_d   = cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Threshold follows the new register values so it is ready for the next sample.
  always_comb begin
    fixed_thr = {adc_d, 4'b0000};
    noise_thr = NoiseW'(sigma_d) * NoiseW'(rms_d);
    margin    = (NoiseW'(fixed_thr) > noise_thr) ? NoiseW'(fixed_thr) : noise_thr;
    thr_d     = ThrW'(mean_d) + ThrW'(margin);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      adc_q   <= AdcThresholdRst;
      sigma_q <= SigmaRst;
      mean_q  <= '0;
      rms_q   <= '0;
      thr_q   <= ThrRst;
    end else begin
      adc_q   <= adc_d;
      sigma_q <= sigma_d;
      mean_q  <= mean_d;
      rms_q   <= rms_d;
      thr_q   <= thr_d;
    end
  end

  assign thr_o  = thr_q;
  assign mean_o = mean_q;

endmodule

// File: design/tpf_front.sv
// Front end: accepts samples, compares them with the threshold and tags
// them with their window index. Depends on tpf_pkg.
module tpf_front #(
  parameter int unsigned MAX_WINDOW  = 65536,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  tpf_pkg::tpf_in_t         in_data_i,
  input  logic [tpf_pkg::ThrW-1:0] thr_i,
  input  logic [tpf_pkg::Q4W-1:0]  mean_i,
  output logic                     push_o,
  output tpf_pkg::tpf_entry_t      entry_o,
  input  logic                     full_i
);
  import tpf_pkg::*;

  localparam logic [IdxW-1:0] IdxMax     = IdxW'(MAX_WINDOW - 1);
  localparam logic [SmpW-1:0] SampleMask = SmpW'((64'd1 << SAMPLE_BITS) - 64'd1);

  logic [IdxW-1:0] idx_q, idx_d;
  logic [Q4W-1:0]  s_q4;
  logic            accept;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;
  assign push_o     = accept;

  // Classify the sample in Q.4.
  always_comb begin
    s_q4                = {in_data_i.sample & SampleMask, 4'b0000};
    entry_o.above       = ThrW'(s_q4) >= thr_i;
    entry_o.diff        = s_q4 - mean_i;
    entry_o.index       = idx_q;
    entry_o.window_end  = in_data_i.window_end;
  end

  // Sample index saturates at the window limit and restarts after a window end.
  always_comb begin
    idx_d = idx_q;
    if (accept) begin
      if (in_data_i.window_end) begin
        idx_d = '0;
      end else if (idx_q < IdxMax) begin
        idx_d = idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni) idx_q <= IdxMax)
    else $error("sample index beyond window limit");

endmodule

// File: design/tpf_queue.sv
// Two-entry queue between the front end and the pulse tracker.
// Depends on tpf_pkg.
module tpf_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  tpf_pkg::tpf_entry_t entry_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                empty_o,
  output tpf_pkg::tpf_entry_t entry_o
);
  import tpf_pkg::*;

  tpf_entry_t  mem_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  count_q;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign entry_o = mem_q[rd_ptr_q];

  // Storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      count_q <= count_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (count_q != 2'd2))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (count_q != 2'd0))
    else $error("queue pop while empty");

endmodule

// File: design/tpf_back.sv
// Pulse tracker: keeps the open pulse record, accumulates area and peak,
// and drives the result register. Depends on tpf_pkg.
module tpf_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                empty_i,
  input  tpf_pkg::tpf_entry_t entry_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tpf_pkg::tpf_out_t   out_data_o
);
  import tpf_pkg::*;

  logic             open_q, open_d;
  logic [IdxW-1:0]  start_q, start_d;
  logic [IdxW-1:0]  pk_idx_q, pk_idx_d;
  logic [AreaW-1:0] area_q, area_d;
  logic [Q4W-1:0]   peak_q, peak_d;
  logic             out_valid_q, out_valid_d;
  tpf_out_t         out_q, out_d;

  logic [AreaW:0]   sum;
  logic [AreaW-1:0] area_acc;
  logic             emit;

  // Take an entry whenever the result register is free or being drained.
  assign pop_o = !empty_i && (!out_valid_q || out_ready_i);

  always_comb begin
    open_d   = open_q;
    start_d  = start_q;
    pk_idx_d = pk_idx_q;
    area_d   = area_q;
    peak_d   = peak_q;
    out_d    = out_q;
    emit     = 1'b0;
    sum      = {1'b0, area_q} + (AreaW+1)'(entry_i.diff);
    area_acc = sum[AreaW] ? AreaMax : sum[AreaW-1:0];

    if (pop_o) begin
      if (entry_i.above) begin
        // Open or extend the pulse; closed records are already zero.
        open_d = 1'b1;
        if (!open_q) begin
          start_d = entry_i.index;
        end
        area_d = area_acc;
        if (peak_q < entry_i.diff) begin
          peak_d   = entry_i.diff;
          pk_idx_d = entry_i.index;
        end
      end else if (open_q) begin
        // Falling crossing closes the pulse; the closing sample is not summed.
        emit              = 1'b1;
        out_d.start_index = start_q;
        out_d.end_index   = (entry_i.index == '0) ? '0 : entry_i.index - 1'b1;
        out_d.peak_index  = pk_idx_q;
        out_d.pulse_area  = area_q;
        out_d.pulse_peak  = peak_q;
        out_d.truncated   = 1'b0;
        open_d            = 1'b0;
        start_d           = '0;
        pk_idx_d          = '0;
        area_d            = '0;
        peak_d            = '0;
      end

      // Window end flushes a pulse still open and clears the record.
      if (entry_i.window_end) begin
        if (entry_i.above) begin
          emit              = 1'b1;
          out_d.start_index = start_d;
          out_d.end_index   = entry_i.index;
          out_d.peak_index  = pk_idx_d;
          out_d.pulse_area  = area_d;
          out_d.pulse_peak  = peak_d;
          out_d.truncated   = 1'b1;
        end
        open_d   = 1'b0;
        start_d  = '0;
        pk_idx_d = '0;
        area_d   = '0;
        peak_d   = '0;
      end
    end

    // Result register handshake.
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Pulse record and result valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q      <= 1'b0;
      start_q     <= '0;
      pk_idx_q    <= '0;
      area_q      <= '0;
      peak_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      open_q      <= open_d;
      start_q     <= start_d;
      pk_idx_q    <= pk_idx_d;
      area_q      <= area_d;
      peak_q      <= peak_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_closed_is_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !open_q |-> (area_q == '0 && peak_q == '0 && pk_idx_q == '0))
    else $error("closed pulse record not cleared");

endmodule

// File: dv/tb_threshold_pulse_finder_unit.sv
// Self-checking testbench for threshold_pulse_finder_unit: a directed table, then
// random windows, checked against a cycle-free predictor of the pulse finder.
// Depends on tpf_pkg and the RTL of threshold_pulse_finder_unit.
module tb_threshold_pulse_finder_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import tpf_pkg::*;

  localparam int unsigned RandomItems = 600;
  // Covers the result register and the two-entry queue, with margin.
  localparam int unsigned DrainCycles = 8;
  localparam logic [CfgIdxW-1:0] CfgUnmapped = 8'hFF;
  localparam logic [IdxW-1:0] IdxSat = 16'hFFFF;

  typedef enum logic {RowCfg, RowSmp} row_kind_e;

  // One row of the directed table: a register write or a sample, with an
  // optional hand-written pulse record.
  typedef struct {
    row_kind_e          kind;
    logic [CfgIdxW-1:0] reg_idx;
    logic [31:0]        reg_data;
    tpf_in_t            smp;
    int unsigned        reps;
    bit                 typed;
    bit                 fires;
    tpf_out_t           rec;
  } dir_row_t;

  logic               clk_i;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  tpf_in_t            in_data_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  tpf_out_t           out_data_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [31:0]        cfg_data_i = '0;

  threshold_pulse_finder_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Predictor copy of the registers and of the open pulse.
  logic [15:0]      thr_adc;
  logic [7:0]       thr_sigma;
  logic [Q4W-1:0]   ped_mean;
  logic [15:0]      ped_rms;
  bit               trk_open;
  logic [IdxW-1:0]  trk_index;
  logic [IdxW-1:0]  trk_start;
  logic [IdxW-1:0]  trk_peak_idx;
  logic [AreaW-1:0] trk_area;
  logic [Q4W-1:0]   trk_peak;

  tpf_out_t    pending_pulses[$];
  dir_row_t    dir_rows[$];
  int unsigned mismatch_cnt = 0;
  int unsigned burst_left;
  bit          streaming = 1'b0;

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Threshold in Q.4 from the current register copy.
  function automatic logic [ThrW-1:0] threshold_q4();
    logic [ThrW-1:0] fixed_q4;
    logic [ThrW-1:0] noise_q4;
    fixed_q4 = ThrW'({thr_adc, 4'b0000});
    noise_q4 = ThrW'(thr_sigma) * ThrW'(ped_rms);
    return ThrW'(ped_mean) + ((fixed_q4 > noise_q4) ? fixed_q4 : noise_q4);
  endfunction

  function automatic void clear_track();
    trk_open     = 1'b0;
    trk_start    = '0;
    trk_peak_idx = '0;
    trk_area     = '0;
    trk_peak     = '0;
  endfunction

  function automatic void append_row(input dir_row_t r);
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  function automatic tpf_out_t pulse_record(input logic [IdxW-1:0] stop_idx, input bit trunc);
    tpf_out_t r;
    r.start_index = trk_start;
    r.end_index   = stop_idx;
    r.peak_index  = trk_peak_idx;
    r.pulse_area  = trk_area;
    r.pulse_peak  = trk_peak;
    r.truncated   = trunc;
    return r;
  endfunction

  // Advances the pulse tracker by one sample and reports a finished pulse.
  task automatic track_pulse(input tpf_in_t smp, output bit fired, output tpf_out_t rec);
    logic [Q4W-1:0]   s_q4;
    logic [Q4W-1:0]   diff;
    logic [AreaW:0]   area_next;
    logic [IdxW-1:0]  idx;
    bit               above;
    s_q4  = {smp.sample, 4'b0000};
    above = {5'b0, s_q4} >= threshold_q4();
    idx   = trk_index;
    fired = 1'b0;
    rec   = '0;
    if (!trk_open && above) begin
      trk_open  = 1'b1;
      trk_start = idx;
    end
    // The first sample below the threshold closes the pulse.
    if (trk_open && !above) begin
      fired = 1'b1;
      rec   = pulse_record((idx == 0) ? '0 : idx - 1'b1, 1'b0);
      clear_track();
    end
    // Accumulate the area with saturation and track the strict maximum.
    if (trk_open) begin
      diff      = s_q4 - ped_mean;
      area_next = {1'b0, trk_area} + (AreaW+1)'(diff);
      trk_area  = area_next[AreaW] ? AreaMax : area_next[AreaW-1:0];
      if (trk_peak < diff) begin
        trk_peak     = diff;
        trk_peak_idx = idx;
      end
    end
    if (idx != IdxSat) trk_index = idx + 1'b1;
    // A window end flushes an open pulse as truncated and clears everything.
    if (smp.window_end) begin
      if (trk_open) begin
        fired = 1'b1;
        rec   = pulse_record(idx, 1'b1);
      end
      clear_track();
      trk_index = '0;
    end
  endtask

  function automatic dir_row_t row_cfg(input logic [CfgIdxW-1:0] idx, input logic [31:0] data);
    dir_row_t r;
    r.kind     = RowCfg;
    r.reg_idx  = idx;
    r.reg_data = data;
    r.smp      = '0;
    r.reps     = 0;
    r.typed    = 1'b0;
    r.fires    = 1'b0;
    r.rec      = '0;
    return r;
  endfunction

  function automatic dir_row_t row_smp(input logic [15:0] smp_v, input bit wend,
                                       input int unsigned reps);
    dir_row_t r;
    r                = row_cfg('0, '0);
    r.kind           = RowSmp;
    r.smp.sample     = smp_v;
    r.smp.window_end = wend;
    r.reps           = reps;
    return r;
  endfunction

  function automatic dir_row_t row_none(input logic [15:0] smp_v, input bit wend);
    dir_row_t r;
    r       = row_smp(smp_v, wend, 1);
    r.typed = 1'b1;
    return r;
  endfunction

  function automatic dir_row_t row_rec(input logic [15:0] smp_v, input bit wend,
                                       input logic [IdxW-1:0] start_idx,
                                       input logic [IdxW-1:0] stop_idx,
                                       input logic [IdxW-1:0] pk_idx,
                                       input logic [AreaW-1:0] area,
                                       input logic [Q4W-1:0] peak, input bit trunc);
    dir_row_t r;
    r                 = row_none(smp_v, wend);
    r.fires           = 1'b1;
    r.rec.start_index = start_idx;
    r.rec.end_index   = stop_idx;
    r.rec.peak_index  = pk_idx;
    r.rec.pulse_area  = area;
    r.rec.pulse_peak  = peak;
    r.rec.truncated   = trunc;
    return r;
  endfunction

  // Register write transaction; valid stays high until the next sample lowers it.
  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CfgAdcThreshold: thr_adc   = data[15:0];
      CfgSigmaMult:    thr_sigma = data[7:0];
      CfgPedestalMean: ped_mean  = data[Q4W-1:0];
      CfgPedestalRms:  ped_rms   = data[15:0];
      default: ;
    endcase
  endtask

  // Sample transaction; the sender runs in bursts with random gaps between them.
  task automatic push_sample(input tpf_in_t d, input bit use_typed, input bit typed_fires,
                             input tpf_out_t typed_rec);
    bit       fired;
    tpf_out_t rec;
    if (cfg_valid_i) cfg_valid_i <= 1'b0;
    in_valid_i <= 1'b1;
    in_data_i  <= d;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    track_pulse(d, fired, rec);
    if (use_typed) begin
      fired = typed_fires;
      rec   = typed_rec;
    end
    if (fired) pending_pulses.insert(pending_pulses.size(), rec);
    streaming = 1'b1;
    burst_left--;
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 16);
    end
  endtask

  // Holds the sender until every pulse record is out and the pipeline is empty.
  task automatic settle_block();
    in_valid_i <= 1'b0;
    while (pending_pulses.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    streaming = 1'b0;
  endtask

  task automatic check_field(input string fname, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", fname, want, got);
      mismatch_cnt++;
    end
  endtask

  // Receiver: ready stretches of random length, short stalls, some long open runs.
  initial begin
    forever begin
      out_ready_i <= 1'b1;
      repeat (($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 12)) @(posedge clk_i);
      out_ready_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  end

  // Result checker: each accepted transaction against the oldest expected record.
  always @(posedge clk_i) begin
    tpf_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_pulses.size() == 0) begin
        $error("pulse record accepted with none expected");
        mismatch_cnt++;
      end else begin
        want = pending_pulses.pop_front();
        check_field("start_index", want.start_index, out_data_o.start_index);
        check_field("end_index", want.end_index, out_data_o.end_index);
        check_field("peak_index", want.peak_index, out_data_o.peak_index);
        check_field("pulse_area", want.pulse_area, out_data_o.pulse_area);
        check_field("pulse_peak", want.pulse_peak, out_data_o.pulse_peak);
        check_field("truncated", want.truncated, out_data_o.truncated);
      end
    end
  end

  // Stimulus: directed table, then random windows under changing thresholds.
  initial begin
    tpf_in_t         smp;
    logic [ThrW:0]   lvl;
    int unsigned     fed;
    int unsigned     n_win;
    int unsigned     win_len;
    int unsigned     run_left;
    bit              want_above;
    bit              leave_open;
    logic [15:0]     adc_v;
    logic [15:0]     rms_v;
    logic [Q4W-1:0]  mean_v;

    thr_adc    = AdcThresholdRst;
    thr_sigma  = SigmaRst;
    ped_mean   = '0;
    ped_rms    = '0;
    trk_index  = '0;
    clear_track();
    burst_left = $urandom_range(1, 16);

    // Reset defaults give a threshold of three counts.
    append_row(row_none(16'd0, 1'b0));
    append_row(row_none(16'd3, 1'b0));
    append_row(row_rec(16'd2, 1'b0, 16'd1, 16'd1, 16'd1, 36'd48, 20'd48, 1'b0));
    // Full-scale sample opening and truncated on the same window end.
    append_row(row_rec(16'hFFFF, 1'b1, 16'd3, 16'd3, 16'd3, 36'hFFFF0,
                       20'hFFFF0, 1'b1));
    // A write to an unmapped index changes nothing.
    append_row(row_cfg(CfgUnmapped, 32'hFFFF_FFFF));
    append_row(row_none(16'd2, 1'b0));
    // Threshold raised to full scale while a pulse is open; upper data bits ignored.
    append_row(row_smp(16'hFFFF, 1'b0, 1));
    append_row(row_cfg(CfgAdcThreshold, 32'hFFFF_0000));
    append_row(row_cfg(CfgSigmaMult, 32'hFFFF_FF00));
    append_row(row_cfg(CfgPedestalMean, 32'hFFFF_FFF0));
    append_row(row_smp(16'hFFFF, 1'b0, 1));
    append_row(row_rec(16'd0, 1'b0, 16'd1, 16'd2, 16'd1, 36'hFFFF0, 20'hFFFF0, 1'b0));
    // Flat pulse exactly at the pedestal keeps a zero peak and peak index.
    append_row(row_smp(16'hFFFF, 1'b0, 2));
    append_row(row_rec(16'd0, 1'b0, 16'd4, 16'd5, 16'd0, 36'd0, 20'd0, 1'b0));
    // A pulse closing on the window-end sample is not truncated.
    append_row(row_none(16'hFFFF, 1'b0));
    append_row(row_rec(16'hFFFE, 1'b1, 16'd7, 16'd7, 16'd0, 36'd0, 20'd0, 1'b0));
    // Noise term at its maximum makes the threshold unreachable.
    append_row(row_cfg(CfgAdcThreshold, 32'h0000_FFFF));
    append_row(row_cfg(CfgSigmaMult, 32'h0000_00FF));
    append_row(row_cfg(CfgPedestalRms, 32'h0000_FFFF));
    append_row(row_cfg(CfgPedestalMean, 32'h0000_0000));
    append_row(row_none(16'hFFFF, 1'b1));
    // Maximum pedestal alone is above any sample.
    append_row(row_cfg(CfgAdcThreshold, 32'h0000_0000));
    append_row(row_cfg(CfgSigmaMult, 32'h0000_0000));
    append_row(row_cfg(CfgPedestalMean, 32'h000F_FFFF));
    append_row(row_none(16'hFFFF, 1'b1));
    // Noise term dominates: 255 times one count gives a threshold of 255.
    append_row(row_cfg(CfgPedestalMean, 32'h0000_0000));
    append_row(row_cfg(CfgSigmaMult, 32'h0000_00FF));
    append_row(row_cfg(CfgPedestalRms, 32'h0000_0010));
    append_row(row_none(16'd254, 1'b0));
    append_row(row_smp(16'd255, 1'b0, 1));
    append_row(row_smp(16'h8000, 1'b0, 1));
    append_row(row_rec(16'd254, 1'b1, 16'd1, 16'd2, 16'd2, 36'd528368, 20'h80000,
                       1'b0));
    append_row(row_none(16'd0, 1'b1));

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Walk the directed table.
    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == RowCfg) begin
        if (streaming) settle_block();
        cfg_write(dir_rows[r].reg_idx, dir_rows[r].reg_data);
      end else begin
        for (int unsigned k = 0; k < dir_rows[r].reps; k++) begin
          push_sample(dir_rows[r].smp, dir_rows[r].typed, dir_rows[r].fires, dir_rows[r].rec);
        end
      end
    end

    // Random phases: new registers, then a few windows of pulse-shaped samples.
    fed        = 0;
    run_left   = 0;
    want_above = 1'b0;
    while (fed < RandomItems) begin
      if (streaming) settle_block();
      case ($urandom_range(0, 7))
        0:       adc_v = 16'h0000;
        1:       adc_v = 16'hFFFF;
        default: adc_v = 16'($urandom_range(0, 200));
      endcase
      case ($urandom_range(0, 7))
        0:       rms_v = 16'h0000;
        1:       rms_v = 16'hFFFF;
        default: rms_v = 16'($urandom_range(0, 100));
      endcase
      case ($urandom_range(0, 9))
        0:       mean_v = '0;
        1:       mean_v = 20'hFFFFF;
        2:       mean_v = 20'($urandom);
        default: mean_v = 20'($urandom_range(0, 20'h3FFFF));
      endcase
      cfg_write(CfgAdcThreshold, {16'($urandom), adc_v});
      cfg_write(CfgSigmaMult, {24'($urandom), 8'($urandom_range(0, 255))});
      cfg_write(CfgPedestalMean, {12'($urandom), mean_v});
      cfg_write(CfgPedestalRms, {16'($urandom), rms_v});
      if ($urandom_range(0, 7) == 0) cfg_write(CfgUnmapped, $urandom);

      n_win      = $urandom_range(1, 3);
      leave_open = ($urandom_range(0, 3) == 0);
      for (int unsigned w = 0; w < n_win; w++) begin
        win_len = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40);
        for (int unsigned k = 0; k < win_len; k++) begin
          if (run_left == 0) begin
            want_above = !want_above;
            run_left   = $urandom_range(1, 8);
          end
          run_left--;
          // Lowest sample that reaches the threshold.
          lvl = ({1'b0, threshold_q4()} + 26'd15) >> 4;
          if ($urandom_range(0, 9) == 0 || (want_above && lvl > 26'hFFFF) ||
              (!want_above && lvl == 0)) begin
            smp.sample = 16'($urandom);
          end else if (want_above) begin
            smp.sample = 16'($urandom_range(int'(lvl), 16'hFFFF));
          end else begin
            smp.sample = 16'($urandom_range(0, int'(lvl) - 1));
          end
          if (k == win_len - 1) begin
            smp.window_end = !(leave_open && w == n_win - 1);
          end else begin
            smp.window_end = ($urandom_range(0, 19) == 0);
          end
          push_sample(smp, 1'b0, 1'b0, '0);
          fed++;
        end
      end
    end

    settle_block();
    if (mismatch_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #15_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
